// ===== hdl/ook_pulse_width_frame_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// OOK pulse-width frame encoder: assertion macros
// Shared macros for the concurrent checks in the encoder top level. Each
// macro expects signals named clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef OOK_PULSE_WIDTH_FRAME_ENCODER_UNIT_DEFINES_SVH
`define OOK_PULSE_WIDTH_FRAME_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OPFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define OPFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/opfe_pkg.sv =====
// ----------------------------------------------------------------------------
// OOK pulse-width frame encoder package
// Register map, reset values and the configuration bundle type.
// ----------------------------------------------------------------------------
package opfe_pkg;

	// APB port geometry.
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_REPEAT_COUNT    = 3'd0;
	localparam logic [2:0] REG_ZERO_HALF_US    = 3'd1;
	localparam logic [2:0] REG_ONE_HALF_US     = 3'd2;
	localparam logic [2:0] REG_PREAMBLE_ZEROS  = 3'd3;
	localparam logic [2:0] REG_GAP_US          = 3'd4;
	localparam logic [2:0] REG_CHECKSUM_ENABLE = 3'd5;
	localparam logic [2:0] REG_CHECKSUM_OFFSET = 3'd6;

	// Reset values of the registers.
	localparam logic [3:0]  RST_REPEAT_COUNT    = 4'd10;
	localparam logic [11:0] RST_ZERO_HALF_US    = 12'd400;
	localparam logic [11:0] RST_ONE_HALF_US     = 12'd600;
	localparam logic [5:0]  RST_PREAMBLE_ZEROS  = 6'd24;
	localparam logic [15:0] RST_GAP_US          = 16'd10000;
	localparam logic        RST_CHECKSUM_ENABLE = 1'b0;
	localparam logic [7:0]  RST_CHECKSUM_OFFSET = 8'd6;

	// Configuration as seen by the encoder core.
	typedef struct packed {
		logic [3:0]  repeat_count;
		logic [11:0] zero_half_us;
		logic [11:0] one_half_us;
		logic [5:0]  preamble_zeros;
		logic [15:0] gap_us;
		logic        checksum_enable;
		logic [7:0]  checksum_offset;
	} opfe_cfg_t;

endpackage

// ===== hdl/opfe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module opfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/opfe_regs.sv =====
// ----------------------------------------------------------------------------
// OOK pulse-width frame encoder register file
// APB slave holding the seven configuration registers of the encoder.
// ----------------------------------------------------------------------------
module opfe_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [opfe_pkg::CFG_AW-1:0] paddr,
	input  logic [opfe_pkg::CFG_DW-1:0] pwdata,
	output logic [opfe_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output opfe_pkg::opfe_cfg_t        cfg
);
	import opfe_pkg::*;

	opfe_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_count    <= RST_REPEAT_COUNT;
			cfg_q.zero_half_us    <= RST_ZERO_HALF_US;
			cfg_q.one_half_us     <= RST_ONE_HALF_US;
			cfg_q.preamble_zeros  <= RST_PREAMBLE_ZEROS;
			cfg_q.gap_us          <= RST_GAP_US;
			cfg_q.checksum_enable <= RST_CHECKSUM_ENABLE;
			cfg_q.checksum_offset <= RST_CHECKSUM_OFFSET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_REPEAT_COUNT:    cfg_q.repeat_count    <= pwdata[3:0];
				REG_ZERO_HALF_US:    cfg_q.zero_half_us    <= pwdata[11:0];
				REG_ONE_HALF_US:     cfg_q.one_half_us     <= pwdata[11:0];
				REG_PREAMBLE_ZEROS:  cfg_q.preamble_zeros  <= pwdata[5:0];
				REG_GAP_US:          cfg_q.gap_us          <= pwdata[15:0];
				REG_CHECKSUM_ENABLE: cfg_q.checksum_enable <= pwdata[0];
				REG_CHECKSUM_OFFSET: cfg_q.checksum_offset <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			REG_REPEAT_COUNT:    prdata = CFG_DW'(cfg_q.repeat_count);
			REG_ZERO_HALF_US:    prdata = CFG_DW'(cfg_q.zero_half_us);
			REG_ONE_HALF_US:     prdata = CFG_DW'(cfg_q.one_half_us);
			REG_PREAMBLE_ZEROS:  prdata = CFG_DW'(cfg_q.preamble_zeros);
			REG_GAP_US:          prdata = CFG_DW'(cfg_q.gap_us);
			REG_CHECKSUM_ENABLE: prdata = CFG_DW'(cfg_q.checksum_enable);
			REG_CHECKSUM_OFFSET: prdata = CFG_DW'(cfg_q.checksum_offset);
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/ook_pulse_width_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// OOK pulse-width frame encoder
// Buffers message bytes and sends them as a repeated on-off keyed frame of
// pulse-width coded bits, one line level per microsecond tick item.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one item per command. tuser selects the kind:
// 0 loads the byte in tdata into the message buffer, with tlast marking
// the final byte that starts transmission; 1 is a one microsecond tick.
// Every accepted item gives exactly one result item on the output stream:
// tdata bit 0 is the line level, bit 1 the busy flag, tlast is set on the
// tick that ends the last repeat, and tuser flags a dropped load.
// Each result is registered in the output register when its item is
// accepted. Throughput is one item per clock when not stalled: the whole
// step is one pass through the sequencer's next-state logic, the bits of
// each stored byte are shifted out of an eight-bit shift register, with
// the next byte fetched from the message RAM ahead of use, and the
// checksum byte is picked bit by bit from the current sum and offset.
// If the receiver stalls, the result is held and the input is stalled
// until the output register is taken. Reset returns the sequencer to idle
// with an empty buffer and loads the register defaults; the buffer needs
// no clearing pass. Configuration is written over the APB port.
// ----------------------------------------------------------------------------
`include "ook_pulse_width_frame_encoder_unit_defines.svh"

module ook_pulse_width_frame_encoder_unit #(
	parameter int MAX_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] byte_value
	input  logic                        s_tuser,  // [0] command
	input  logic                        s_tlast,  // last_byte
	// Output stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // [0] line_level, [1] busy_res, [7:2] zero
	output logic                        m_tuser,  // [0] load_dropped
	output logic                        m_tlast,  // frame_done
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [opfe_pkg::CFG_AW-1:0] paddr,
	input  logic [opfe_pkg::CFG_DW-1:0] pwdata,
	output logic [opfe_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);
	import opfe_pkg::*;

	localparam int AW = $clog2(MAX_BYTES);
	localparam int TW = $clog2(MAX_BYTES + 1);
	localparam int IW = $clog2(MAX_BYTES + 2);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREAMBLE,
		PH_SYNC,
		PH_DATA,
		PH_PARITY,
		PH_TRAILER,
		PH_GAP
	} phase_t;

	opfe_cfg_t cfg;

	phase_t        phase_q, n_phase;
	logic [TW-1:0] byte_total_q, n_total;
	logic [7:0]    sum_q, n_sum;
	logic [3:0]    rep_q, n_rep;
	logic [IW-1:0] byte_idx_q, n_byte;
	logic [5:0]    bit_idx_q, n_bit;
	logic          par_q, n_par;
	logic          half_q, n_half;
	logic [15:0]   time_q, n_time;
	logic [7:0]    sr_q, n_sr;

	logic          m_tvalid_q;
	logic          level_q, busy_q, done_q, drop_q;
	logic          level_c, busy_c, done_c, drop_c;

	logic          in_acc;
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [IW-1:0] idx_inc;
	logic [IW-1:0] frame_len;
	logic [7:0]    cks;
	logic          cks_byte;
	logic          cur_bit;

	// Half period of a bit; a programmed zero acts as one.
	function automatic logic [15:0] half_len(input logic b, input opfe_cfg_t c);
		logic [11:0] d;
		d = b ? c.one_half_us : c.zero_half_us;
		return (d == '0) ? 16'd1 : {4'd0, d};
	endfunction

	opfe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Message buffer; the read port prefetches the byte after the current one.
	opfe_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (byte_total_q[AW-1:0]),
		.wdata (s_tdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;

	// Read address: byte zero outside the data bytes, else the next byte.
	assign idx_inc = byte_idx_q + 1'b1;
	always_comb begin
		if ((phase_q == PH_DATA || phase_q == PH_PARITY) && idx_inc < IW'(MAX_BYTES)) begin
			rd_addr = idx_inc[AW-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	assign frame_len = IW'(byte_total_q) + IW'(cfg.checksum_enable);
	assign cks       = sum_q + cfg.checksum_offset;

	// Positions past the stored bytes carry the checksum, read from the
	// current sum and offset on every bit.
	assign cks_byte  = (byte_idx_q >= IW'(byte_total_q));

	// Bit being sent in the current phase.
	always_comb begin
		case (phase_q)
			PH_SYNC:   cur_bit = 1'b1;
			PH_DATA:   cur_bit = cks_byte ? cks[3'd7 - bit_idx_q[2:0]] : sr_q[7];
			PH_PARITY: cur_bit = par_q;
			default:   cur_bit = 1'b0;
		endcase
	end

	// Sequencer next state for one accepted item.
	always_comb begin
		logic       enter;
		logic       ebit;
		logic       sbyte;
		logic       end_rep;
		logic       start_rep;
		logic       par_new;
		logic [6:0] bit_inc;
		logic [3:0] rep_inc;
		logic [3:0] rep_cnt;

		n_phase   = phase_q;
		n_total   = byte_total_q;
		n_sum     = sum_q;
		n_rep     = rep_q;
		n_byte    = byte_idx_q;
		n_bit     = bit_idx_q;
		n_par     = par_q;
		n_half    = half_q;
		n_time    = time_q;
		n_sr      = sr_q;
		level_c   = 1'b0;
		busy_c    = 1'b0;
		done_c    = 1'b0;
		drop_c    = 1'b0;
		wr_en     = 1'b0;
		enter     = 1'b0;
		ebit      = 1'b0;
		sbyte     = 1'b0;
		end_rep   = 1'b0;
		start_rep = 1'b0;
		par_new   = par_q ^ cur_bit;
		bit_inc   = {1'b0, bit_idx_q} + 7'd1;
		rep_inc   = rep_q + 4'd1;
		rep_cnt   = (cfg.repeat_count == '0) ? 4'd1 : cfg.repeat_count;

		if (in_acc) begin
			if (!s_tuser) begin
				// Byte load: only taken while idle and with room left.
				if (phase_q != PH_IDLE) begin
					drop_c = 1'b1;
				end else begin
					if (byte_total_q < TW'(MAX_BYTES)) begin
						wr_en   = 1'b1;
						n_total = byte_total_q + 1'b1;
						n_sum   = sum_q + s_tdata;
					end else begin
						drop_c = 1'b1;
					end
					if (s_tlast) begin
						n_rep     = '0;
						start_rep = 1'b1;
					end
				end
			end else if (phase_q != PH_IDLE) begin
				// Tick: report the level held, then count down the segment.
				busy_c  = 1'b1;
				level_c = (phase_q != PH_GAP) && !half_q;
				if (time_q <= 16'd1) begin
					if (phase_q == PH_GAP) begin
						end_rep = 1'b1;
					end else if (!half_q) begin
						n_half = 1'b1;
						n_time = half_len(cur_bit, cfg);
					end else begin
						case (phase_q)
							PH_PREAMBLE: begin
								n_bit = bit_inc[5:0];
								enter = 1'b1;
								if (bit_inc >= {1'b0, cfg.preamble_zeros}) begin
									n_phase = PH_SYNC;
									ebit    = 1'b1;
								end else begin
									n_phase = PH_PREAMBLE;
								end
							end
							PH_SYNC: begin
								n_byte = '0;
								sbyte  = 1'b1;
							end
							PH_DATA: begin
								n_par = par_new;
								n_bit = bit_inc[5:0];
								n_sr  = {sr_q[6:0], 1'b0};
								enter = 1'b1;
								if (bit_inc >= 7'd8) begin
									n_phase = PH_PARITY;
									ebit    = par_new;
								end else begin
									n_phase = PH_DATA;
									ebit    = cks_byte ? cks[3'd7 - bit_inc[2:0]] : sr_q[6];
								end
							end
							PH_PARITY: begin
								n_byte = byte_idx_q + 1'b1;
								sbyte  = 1'b1;
							end
							default: begin
								if (cfg.gap_us == '0) begin
									end_rep = 1'b1;
								end else begin
									n_phase = PH_GAP;
									n_half  = 1'b0;
									n_time  = cfg.gap_us;
								end
							end
						endcase
					end
				end else begin
					n_time = time_q - 16'd1;
				end
			end

			// Start of a byte: load the shift register or go to the trailer.
			if (sbyte) begin
				n_bit = '0;
				n_par = 1'b0;
				enter = 1'b1;
				if (n_byte < frame_len) begin
					n_phase = PH_DATA;
					n_sr    = (n_byte < IW'(byte_total_q)) ? rd_data : cks;
					ebit    = n_sr[7];
				end else begin
					n_phase = PH_TRAILER;
					ebit    = 1'b0;
				end
			end

			// End of a repeat: next repeat or back to idle.
			if (end_rep) begin
				if (rep_inc == '0 || rep_inc >= rep_cnt) begin
					n_phase = PH_IDLE;
					n_rep   = '0;
					n_byte  = '0;
					n_bit   = '0;
					n_par   = 1'b0;
					n_half  = 1'b0;
					n_time  = '0;
					n_total = '0;
					n_sum   = '0;
					done_c  = 1'b1;
				end else begin
					n_rep     = rep_inc;
					start_rep = 1'b1;
				end
			end

			// Start of a repeat: preamble, or the sync bit when it is empty.
			if (start_rep) begin
				n_bit = '0;
				enter = 1'b1;
				if (cfg.preamble_zeros != '0) begin
					n_phase = PH_PREAMBLE;
					ebit    = 1'b0;
				end else begin
					n_phase = PH_SYNC;
					ebit    = 1'b1;
				end
			end

			// Entering a bit begins its high half.
			if (enter) begin
				n_half = 1'b0;
				n_time = half_len(ebit, cfg);
			end

			// A load reports the state after it.
			if (!s_tuser) begin
				busy_c  = (n_phase != PH_IDLE);
				level_c = (n_phase != PH_IDLE) && (n_phase != PH_GAP) && !n_half;
			end
		end
	end

	// Sequencer state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_total_q <= '0;
			sum_q        <= '0;
			rep_q        <= '0;
			byte_idx_q   <= '0;
			bit_idx_q    <= '0;
			par_q        <= 1'b0;
			half_q       <= 1'b0;
			time_q       <= '0;
			sr_q         <= '0;
			m_tvalid_q   <= 1'b0;
			level_q      <= 1'b0;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			drop_q       <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q      <= n_phase;
				byte_total_q <= n_total;
				sum_q        <= n_sum;
				rep_q        <= n_rep;
				byte_idx_q   <= n_byte;
				bit_idx_q    <= n_bit;
				par_q        <= n_par;
				half_q       <= n_half;
				time_q       <= n_time;
				sr_q         <= n_sr;
				m_tvalid_q   <= 1'b1;
				level_q      <= level_c;
				busy_q       <= busy_c;
				done_q       <= done_c;
				drop_q       <= drop_c;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, busy_q, level_q};
	assign m_tuser  = drop_q;
	assign m_tlast  = done_q;

	// Checks on the sequencer.
	`OPFE_ASSERT_NXT(a_done_idle, in_acc && done_c, phase_q == PH_IDLE && byte_total_q == '0, "frame end did not return to idle with an empty buffer")
	`OPFE_ASSERT_NXT(a_busy_drop, in_acc && !s_tuser && phase_q != PH_IDLE, m_tvalid_q && drop_q, "load during a frame was not flagged as dropped")
	`OPFE_ASSERT_IMP(a_level_busy, m_tvalid_q && level_q, busy_q, "line driven high outside a frame")
	`OPFE_ASSERT_IMP(a_total_bound, 1'b1, byte_total_q <= TW'(MAX_BYTES), "byte count beyond buffer depth")

endmodule
